### design/pbcr_pkg.sv
// Shared constants, opcodes and types of the blade column renderer.
package pbcr_pkg;

   localparam int IMAGE_COLUMNS = 128;
   localparam int IMAGE_ROWS    = 36;
   localparam int ARM_LEDS      = 36;

   localparam int IMG_PIXELS = IMAGE_COLUMNS * IMAGE_ROWS;
   localparam int IMG_BYTES  = IMG_PIXELS * 3;
   localparam int LIT_COUNT  = (IMAGE_ROWS < ARM_LEDS) ? IMAGE_ROWS : ARM_LEDS;

   localparam int PIX_AW    = $clog2(2 * IMG_PIXELS);
   localparam int COL_W     = $clog2(IMAGE_COLUMNS);
   localparam int ROW_W     = (IMAGE_ROWS > 1) ? $clog2(IMAGE_ROWS) : 1;
   localparam int LED_W     = (ARM_LEDS > 1) ? $clog2(ARM_LEDS) : 1;
   localparam int PERIOD_W  = 24;
   localparam int ELAPSED_W = 48;
   localparam int BYTE_AW   = 14;
   localparam int PIXEL_W   = 24;

   // Fixed-point reciprocal of three; exact floor for byte addresses below 32768.
   localparam int RECIP3 = 21846;

   localparam logic [1:0] OP_WRITE      = 2'd0;
   localparam logic [1:0] OP_COMMIT     = 2'd1;
   localparam logic [1:0] OP_INVALIDATE = 2'd2;
   localparam logic [1:0] OP_RENDER     = 2'd3;

   localparam logic [1:0] CSR_STRIP_ENABLE = 2'd0;
   localparam logic [1:0] CSR_BRIGHTNESS   = 2'd1;
   localparam logic [1:0] CSR_PERIOD       = 2'd2;

   typedef struct packed {
      logic             done;
      logic [COL_W-1:0] col_a;
      logic [COL_W-1:0] col_b;
   } div_status_type;

   typedef struct packed {
      logic              en;
      logic [PIX_AW-1:0] addr_a;
      logic [PIX_AW-1:0] addr_b;
   } ram_read_type;

endpackage

### design/pov_blade_column_renderer_core.sv
// Top level of the blade column renderer: request decode, sequencer and result stage.
//
// Requests arrive on the req_ stream: tuser carries the opcode, tdata the byte address,
// byte value and elapsed time. Writes, commits and invalidates are taken one per
// cycle while the block is idle and produce no results. A render request closes
// req_tready while the shared divider first reduces the time modulo the rotation
// period (48 steps) and then scales the position to a column (31 steps, one bit per
// cycle each). Results then leave on the rsp_ stream at one per cycle while the
// receiver takes them, ARM_LEDS of them, the last marked by tlast. A stalled receiver
// holds the result in the output stage and pauses the memory reads; nothing is lost.
// The csr_ port writes strip enable, global brightness and rotation period; the user
// must use it only while the block is idle, and the block itself does not enforce
// this. Reset (synchronous) clears the shown buffer select and the image valid mark
// and restores register defaults; the pixel memory is not cleared and needs no sweep.
module pov_blade_column_renderer_core
   import pbcr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: byte_address[13:0], byte_value[21:14], elapsed_us[69:22], zero pad
   input  logic [71:0] req_tdata,
   // tuser: opcode[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: led_index[5:0], bright_a[10:6], red_a[18:11], green_a[26:19], blue_a[34:27],
   //        bright_b[39:35], red_b[47:40], green_b[55:48], blue_b[63:56]
   output logic [63:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_EMIT = 2'd2;

   localparam logic [PIX_AW-1:0] PIX_OFFSET = PIX_AW'(IMG_PIXELS);

   logic [1:0]          state_ff, state_in;
   logic                strip_en_ff;
   logic [4:0]          bright_ff;
   logic [PERIOD_W-1:0] period_ff;
   logic                shown_ff, shown_in;
   logic                valid_ff, valid_in;
   logic [LED_W-1:0]    led_ff, led_in;
   logic [COL_W-1:0]    col_a_ff, col_a_in;
   logic [COL_W-1:0]    col_b_ff, col_b_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_lit_ff, out_lit_in;
   logic                out_last_ff, out_last_in;
   logic [LED_W-1:0]    out_led_ff, out_led_in;

   logic                req_fire;
   logic                back_buf;
   logic [BYTE_AW-1:0]  byte_addr;
   logic [28:0]         recip_prod;
   logic [12:0]         pixel;
   logic [BYTE_AW-1:0]  lane_full;
   logic                wr_en;
   logic [PIX_AW-1:0]   wr_addr;
   logic                issue;
   logic                row_ok;
   logic [ROW_W-1:0]    row_a;
   logic [ROW_W-1:0]    row_b;
   ram_read_type        rd;
   div_status_type      div_status;
   logic [PIXEL_W-1:0]  pix_a;
   logic [PIXEL_W-1:0]  pix_b;
   logic [PIXEL_W-1:0]  lit_a;
   logic [PIXEL_W-1:0]  lit_b;
   logic [4:0]          lit_bright;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign back_buf   = valid_ff && !shown_ff;

   // Byte address split into pixel and color lane by a reciprocal multiply.
   always_comb begin
      byte_addr  = req_tdata[13:0];
      recip_prod = 29'(byte_addr) * 29'(RECIP3);
      pixel      = recip_prod[28:16];
      lane_full  = byte_addr - BYTE_AW'(pixel * 3);
      wr_en      = req_fire && (req_tuser == OP_WRITE) && (32'(byte_addr) < 32'(IMG_BYTES));
      wr_addr    = (back_buf ? PIX_OFFSET : '0) + PIX_AW'(pixel);
   end

   always_comb begin
      state_in = state_ff;
      shown_in = shown_ff;
      valid_in = valid_ff;
      led_in   = led_ff;
      col_a_in = col_a_ff;
      col_b_in = col_b_ff;
      issue    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  OP_COMMIT: begin
                     shown_in = back_buf;
                     valid_in = 1'b1;
                  end
                  OP_INVALIDATE: valid_in = 1'b0;
                  OP_RENDER:     state_in = S_DIV;
                  default: ;
               endcase
            end
         end
         S_DIV: begin
            if (div_status.done) begin
               col_a_in = div_status.col_a;
               col_b_in = div_status.col_b;
               led_in   = '0;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            // A read is issued only when the output stage will be free to take it.
            if (!rsp_valid_ff || rsp_tready) begin
               issue  = 1'b1;
               led_in = led_ff + LED_W'(1);
               if (led_ff == LED_W'(ARM_LEDS - 1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      row_ok = 32'(led_ff) < 32'(LIT_COUNT);
      row_a  = row_ok ? ROW_W'(IMAGE_ROWS - 1 - 32'(led_ff)) : '0;
      row_b  = row_ok ? ROW_W'(led_ff) : '0;
      rd.en     = issue;
      rd.addr_a = (shown_ff ? PIX_OFFSET : '0) + PIX_AW'(col_a_ff) * PIX_AW'(IMAGE_ROWS)
                  + PIX_AW'(row_a);
      rd.addr_b = (shown_ff ? PIX_OFFSET : '0) + PIX_AW'(col_b_ff) * PIX_AW'(IMAGE_ROWS)
                  + PIX_AW'(row_b);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      out_lit_in   = out_lit_ff;
      out_last_in  = out_last_ff;
      out_led_in   = out_led_ff;
      if (issue) begin
         rsp_valid_in = 1'b1;
         out_lit_in   = strip_en_ff && valid_ff && row_ok;
         out_last_in  = (led_ff == LED_W'(ARM_LEDS - 1));
         out_led_in   = led_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         shown_ff     <= 1'b0;
         valid_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         strip_en_ff  <= 1'b0;
         bright_ff    <= 5'd31;
         period_ff    <= PERIOD_W'(50000);
      end else begin
         state_ff     <= state_in;
         shown_ff     <= shown_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_STRIP_ENABLE: strip_en_ff <= csr_wdata[0];
               CSR_BRIGHTNESS:   bright_ff   <= csr_wdata[4:0];
               CSR_PERIOD:       period_ff   <= csr_wdata;
               default: ;
            endcase
         end
      end
      led_ff      <= led_in;
      col_a_ff    <= col_a_in;
      col_b_ff    <= col_b_in;
      out_lit_ff  <= out_lit_in;
      out_last_ff <= out_last_in;
      out_led_ff  <= out_led_in;
   end

   pbcr_col_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (req_fire && (req_tuser == OP_RENDER)),
      .period  (period_ff),
      .elapsed (req_tdata[69:22]),
      .status  (div_status)
   );

   pbcr_image_ram u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_lane   (lane_full[1:0]),
      .wr_byte   (req_tdata[21:14]),
      .rd        (rd),
      .rd_data_a (pix_a),
      .rd_data_b (pix_b)
   );

   assign lit_a      = out_lit_ff ? pix_a : '0;
   assign lit_b      = out_lit_ff ? pix_b : '0;
   assign lit_bright = out_lit_ff ? bright_ff : 5'd0;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {lit_b[23:16], lit_b[15:8], lit_b[7:0], lit_bright,
                        lit_a[23:16], lit_a[15:8], lit_a[7:0], lit_bright,
                        6'(out_led_ff)};

endmodule

### design/pbcr_col_divider.sv
// Shared restoring divider that turns elapsed time into the two blade columns.
module pbcr_col_divider
   import pbcr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [PERIOD_W-1:0]  period,
   input  logic [ELAPSED_W-1:0] elapsed,
   output div_status_type       status
);

   localparam int P2_W  = PERIOD_W + COL_W;
   localparam int CNT_W = $clog2(ELAPSED_W);
   localparam logic [COL_W:0] COLS_X  = (COL_W + 1)'(IMAGE_COLUMNS);
   localparam logic [COL_W:0] HALF_X  = (COL_W + 1)'(IMAGE_COLUMNS / 2);
   localparam logic [COL_W:0] LAST_X  = (COL_W + 1)'(IMAGE_COLUMNS - 1);

   logic                 busy_ff, busy_in;
   logic                 phase_ff, phase_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [PERIOD_W:0]    rem_ff, rem_in;
   logic [ELAPSED_W-1:0] dvd_ff, dvd_in;
   logic [COL_W-1:0]     quo_ff, quo_in;
   logic [PERIOD_W-1:0]  period_ff, period_in;
   logic [COL_W-1:0]     col_a_ff, col_a_in;
   logic [COL_W-1:0]     col_b_ff, col_b_in;

   logic [PERIOD_W:0]    rem_shift;
   logic                 ge;
   logic [PERIOD_W:0]    rem_step;
   logic [P2_W-1:0]      scaled;
   logic [COL_W:0]       col_clamp;
   logic [COL_W:0]       col_sum;

   // One restoring step per cycle: shift in the next dividend bit, subtract if it fits.
   always_comb begin
      rem_shift = {rem_ff[PERIOD_W-1:0], dvd_ff[ELAPSED_W-1]};
      ge        = rem_shift >= {1'b0, period_ff};
      rem_step  = ge ? (rem_shift - {1'b0, period_ff}) : rem_shift;
      scaled    = P2_W'(rem_step[PERIOD_W-1:0]) * P2_W'(IMAGE_COLUMNS);
      col_clamp = {1'b0, quo_ff[COL_W-2:0], ge};
      if (col_clamp >= COLS_X) begin
         col_clamp = LAST_X;
      end
      col_sum = col_clamp + HALF_X;
      if (col_sum >= COLS_X) begin
         col_sum = col_sum - COLS_X;
      end
   end

   always_comb begin
      busy_in   = busy_ff;
      phase_in  = phase_ff;
      done_in   = 1'b0;
      count_in  = count_ff;
      rem_in    = rem_ff;
      dvd_in    = dvd_ff;
      quo_in    = COL_W'({quo_ff, ge});
      period_in = period_ff;
      col_a_in  = col_a_ff;
      col_b_in  = col_b_ff;
      if (!busy_ff) begin
         quo_in = quo_ff;
         if (start) begin
            busy_in   = 1'b1;
            phase_in  = 1'b0;
            count_in  = CNT_W'(ELAPSED_W - 1);
            rem_in    = '0;
            dvd_in    = elapsed;
            period_in = (period == '0) ? PERIOD_W'(1) : period;
         end
      end else begin
         rem_in = rem_step;
         dvd_in = {dvd_ff[ELAPSED_W-2:0], 1'b0};
         if (count_ff == '0) begin
            if (!phase_ff) begin
               // The remainder is the position within the turn; scale it by the column count.
               phase_in = 1'b1;
               count_in = CNT_W'(P2_W - 1);
               rem_in   = '0;
               dvd_in   = ELAPSED_W'(scaled) << (ELAPSED_W - P2_W);
               quo_in   = '0;
            end else begin
               busy_in  = 1'b0;
               done_in  = 1'b1;
               col_a_in = col_clamp[COL_W-1:0];
               col_b_in = col_sum[COL_W-1:0];
            end
         end else begin
            count_in = count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      phase_ff  <= phase_in;
      count_ff  <= count_in;
      rem_ff    <= rem_in;
      dvd_ff    <= dvd_in;
      quo_ff    <= quo_in;
      period_ff <= period_in;
      col_a_ff  <= col_a_in;
      col_b_ff  <= col_b_in;
   end

   assign status.done  = done_ff;
   assign status.col_a = col_a_ff;
   assign status.col_b = col_b_ff;

endmodule

### design/pbcr_image_ram.sv
// Double-buffered pixel memory with byte-lane writes and two registered read ports.
module pbcr_image_ram
   import pbcr_pkg::*;
(
   input  logic               clock,
   input  logic               wr_en,
   input  logic [PIX_AW-1:0]  wr_addr,
   input  logic [1:0]         wr_lane,
   input  logic [7:0]         wr_byte,
   input  ram_read_type       rd,
   output logic [PIXEL_W-1:0] rd_data_a,
   output logic [PIXEL_W-1:0] rd_data_b
);

   logic [PIXEL_W-1:0] mem [2 * IMG_PIXELS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr][{wr_lane, 3'b000} +: 8] <= wr_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_a <= mem[rd.addr_a];
         rd_data_b <= mem[rd.addr_b];
      end
   end

endmodule

### design/pbcr_checker.sv
// Port-level checks of the blade column renderer and their bind to the top level.
module pbcr_checker
   import pbcr_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tlast
);

   // A result that is offered stays offered until taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // A render request blocks further requests while it runs.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_RENDER) |=> !req_tready)
      else $error("request accepted during a render");

   // Only the final result of a render may be pending while requests are taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("ready while a render is still emitting");

   // The last flag marks exactly the final LED.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[5:0] == 6'(ARM_LEDS - 1))))
      else $error("last flag does not match the LED index");

   // Both arms are lit or dark together with the same brightness.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[10:6] == rsp_tdata[39:35]))
      else $error("arm brightness mismatch");

endmodule

bind pov_blade_column_renderer_core pbcr_checker u_pbcr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

### dv/pov_blade_column_renderer_checker.sv
// Checker for the blade column renderer: predicts every LED result and compares it field by field.
module pov_blade_column_renderer_checker
   import pbcr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   // tdata: byte_address[13:0], byte_value[21:14], elapsed_us[69:22], zero pad
   input  logic [71:0] req_tdata,
   // tuser: opcode[1:0]
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: led_index[5:0], bright_a[10:6], red_a[18:11], green_a[26:19], blue_a[34:27],
   //        bright_b[39:35], red_b[47:40], green_b[55:48], blue_b[63:56]
   input  logic [63:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata,
   output int          fail_count,
   output int          results_pending
);

   typedef struct packed {
      logic [7:0] blue_b;
      logic [7:0] green_b;
      logic [7:0] red_b;
      logic [4:0] bright_b;
      logic [7:0] blue_a;
      logic [7:0] green_a;
      logic [7:0] red_a;
      logic [4:0] bright_a;
      logic [5:0] led_index;
   } led_word_t;

   typedef struct packed {
      logic      last_led;
      led_word_t word;
   } led_result_t;

   logic [7:0]  pixel_mem [2*IMG_BYTES];
   bit          shown_sel;
   bit          img_valid;
   bit          strip_enabled;
   logic [4:0]  brightness;
   logic [23:0] period_reg;
   led_result_t expected_leds [$];
   int          mismatches = 0;

   function automatic logic [7:0] stored_byte(int col, int row, int color);
      return pixel_mem[int'(shown_sel) * IMG_BYTES + (col * IMAGE_ROWS + row) * 3 + color];
   endfunction

   // A render request yields one result per arm LED; arm A runs its column bottom up.
   function automatic void queue_render(logic [47:0] elapsed);
      longint unsigned per;
      longint unsigned pos;
      int              col_a;
      int              col_b;
      int              src_row;
      bit              lit;
      led_result_t     res;
      per = (period_reg == '0) ? 64'd1 : 64'(period_reg);
      pos = elapsed % per;
      col_a = int'((pos * IMAGE_COLUMNS) / per);
      if (col_a >= IMAGE_COLUMNS) col_a = IMAGE_COLUMNS - 1;
      col_b = (col_a + IMAGE_COLUMNS / 2) % IMAGE_COLUMNS;
      lit = strip_enabled && img_valid;
      for (int led = 0; led < ARM_LEDS; led++) begin
         res = '0;
         res.word.led_index = 6'(led);
         res.last_led = (led == ARM_LEDS - 1);
         if (lit && led < LIT_COUNT && led < IMAGE_ROWS) begin
            src_row = IMAGE_ROWS - 1 - led;
            res.word.bright_a = brightness;
            res.word.red_a    = stored_byte(col_a, src_row, 0);
            res.word.green_a  = stored_byte(col_a, src_row, 1);
            res.word.blue_a   = stored_byte(col_a, src_row, 2);
            res.word.bright_b = brightness;
            res.word.red_b    = stored_byte(col_b, led, 0);
            res.word.green_b  = stored_byte(col_b, led, 1);
            res.word.blue_b   = stored_byte(col_b, led, 2);
         end
         expected_leds.push_back(res);
      end
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : monitor
      led_word_t   got;
      led_result_t want;
      bit          back_sel;
      if (reset) begin
         shown_sel     = 1'b0;
         img_valid     = 1'b0;
         strip_enabled = 1'b0;
         brightness    = 5'd31;
         period_reg    = 24'd50000;
         expected_leds.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_STRIP_ENABLE: strip_enabled = csr_wdata[0];
               CSR_BRIGHTNESS:   brightness = csr_wdata[4:0];
               CSR_PERIOD:       period_reg = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_leds.size() == 0) begin
               $error("LED result arrived with no render request pending");
               mismatches++;
            end else begin
               want = expected_leds.pop_front();
               got  = rsp_tdata;
               check_field("led_index", 8'(want.word.led_index), 8'(got.led_index));
               check_field("bright_a", 8'(want.word.bright_a), 8'(got.bright_a));
               check_field("red_a", want.word.red_a, got.red_a);
               check_field("green_a", want.word.green_a, got.green_a);
               check_field("blue_a", want.word.blue_a, got.blue_a);
               check_field("bright_b", 8'(want.word.bright_b), 8'(got.bright_b));
               check_field("red_b", want.word.red_b, got.red_b);
               check_field("green_b", want.word.green_b, got.green_b);
               check_field("blue_b", want.word.blue_b, got.blue_b);
               check_field("last_led", 8'(want.last_led), 8'(rsp_tlast));
            end
         end
         if (req_tvalid && req_tready) begin
            // The back buffer is bank one only while a valid image is shown from bank zero.
            back_sel = img_valid && !shown_sel;
            case (req_tuser)
               OP_WRITE: begin
                  if (req_tdata[13:0] < IMG_BYTES)
                     pixel_mem[int'(back_sel) * IMG_BYTES + req_tdata[13:0]] = req_tdata[21:14];
               end
               OP_COMMIT: begin
                  shown_sel = back_sel;
                  img_valid = 1'b1;
               end
               OP_INVALIDATE: img_valid = 1'b0;
               default: queue_render(req_tdata[69:22]);
            endcase
         end
      end
      fail_count      <= mismatches;
      results_pending <= expected_leds.size();
   end

endmodule

### dv/pov_blade_column_renderer_core_test.sv
// Stimulus and verdict for the blade column renderer: image loads, commits, renders, registers.
module pov_blade_column_renderer_core_test;
   import pbcr_pkg::*;

   localparam logic [1:0] CSR_SPARE = 2'd3;
   localparam int COLUMN_BYTES = IMAGE_ROWS * 3;
   localparam int HALF_TURN    = IMAGE_COLUMNS / 2;
   localparam int DRAIN_CYCLES = 150;
   localparam int HOLD_CYCLES  = 700;
   localparam int CYCLE_LIMIT  = 600000;
   localparam longint unsigned ELAPSED_MAX = 64'h0000_FFFF_FFFF_FFFF;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [23:0] csr_wdata;
   int          fail_count;
   int          results_pending;

   int   send_idle_pct = 9;
   int   recv_idle_pct = 68;
   logic pressure_go = 1'b0;
   logic hold_rsp = 1'b0;

   // Which image bytes have been written, so that a lit render only reads filled columns.
   bit          written [2*IMG_BYTES];
   bit          shadow_shown = 1'b0;
   bit          shadow_valid = 1'b0;
   bit          cur_strip = 1'b0;
   int unsigned cur_period = 50000;
   int          extra_pair [2];

   pov_blade_column_renderer_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   pov_blade_column_renderer_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .results_pending (results_pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   always @(posedge clock) begin
      rsp_tready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
   end

   // Long receiver hold-off so that the block fills up and closes its request side.
   initial begin : hold_off
      wait (pressure_go === 1'b1);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   function automatic bit back_sel();
      return shadow_valid && !shadow_shown;
   endfunction

   function automatic logic [47:0] noise48();
      logic [63:0] n;
      n = {$urandom, $urandom};
      return n[47:0];
   endfunction

   function automatic bit column_written(bit bank, int col);
      for (int b = 0; b < COLUMN_BYTES; b++)
         if (!written[int'(bank) * IMG_BYTES + col * COLUMN_BYTES + b]) return 1'b0;
      return 1'b1;
   endfunction

   // A lit render must land on a column whose partner half a turn away is filled too.
   function automatic logic [47:0] pick_elapsed();
      longint unsigned per;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned pos;
      longint unsigned kmax;
      longint unsigned k;
      logic [63:0]     n;
      int              cols [$];
      int              col;
      if (!(cur_strip && shadow_valid)) return noise48();
      per = (cur_period == 0) ? 64'd1 : 64'(cur_period);
      for (int c = 0; c < IMAGE_COLUMNS; c++) begin
         lo = (c * per + IMAGE_COLUMNS - 1) / IMAGE_COLUMNS;
         hi = ((c + 1) * per + IMAGE_COLUMNS - 1) / IMAGE_COLUMNS;
         if (lo < hi && column_written(shadow_shown, c) &&
             column_written(shadow_shown, (c + HALF_TURN) % IMAGE_COLUMNS))
            cols.push_back(c);
      end
      col = cols[$urandom_range(cols.size() - 1)];
      lo = (col * per + IMAGE_COLUMNS - 1) / IMAGE_COLUMNS;
      hi = ((col + 1) * per + IMAGE_COLUMNS - 1) / IMAGE_COLUMNS;
      n = {$urandom, $urandom};
      pos = lo + n % (hi - lo);
      kmax = (ELAPSED_MAX - pos) / per;
      n = {$urandom, $urandom};
      k = ($urandom_range(7) == 0) ? kmax : n % (kmax + 1);
      return 48'(k * per + pos);
   endfunction

   task automatic send_request(logic [1:0] op, logic [13:0] addr, logic [7:0] value,
                               logic [47:0] elapsed);
      bit bank;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, elapsed, value, addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bank = back_sel();
      case (op)
         OP_WRITE:      if (addr < IMG_BYTES) written[int'(bank) * IMG_BYTES + addr] = 1'b1;
         OP_COMMIT: begin
            shadow_shown = bank;
            shadow_valid = 1'b1;
         end
         OP_INVALIDATE: shadow_valid = 1'b0;
         default: ;
      endcase
   endtask

   task automatic send_render(logic [47:0] elapsed);
      send_request(OP_RENDER, 14'($urandom), 8'($urandom), elapsed);
   endtask

   task automatic fill_pair(int pair);
      for (int half = 0; half < 2; half++)
         for (int b = 0; b < COLUMN_BYTES; b++)
            send_request(OP_WRITE, 14'((pair + half * HALF_TURN) * COLUMN_BYTES + b),
                         8'($urandom), noise48());
   endtask

   task automatic write_csr(logic [1:0] idx, logic [23:0] value, bit keep_enable);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      if (!keep_enable) csr_wr_en <= 1'b0;
      case (idx)
         CSR_STRIP_ENABLE: cur_strip = value[0];
         CSR_PERIOD:       cur_period = 32'(value);
         default: ;
      endcase
   endtask

   // Enable stays high across the burst; unused upper bits carry noise.
   task automatic set_registers(bit strip, logic [4:0] bright, logic [23:0] period);
      logic [23:0] noise;
      noise = 24'($urandom);
      write_csr(CSR_SPARE, noise, 1'b1);
      write_csr(CSR_STRIP_ENABLE, {noise[23:1], strip}, 1'b1);
      write_csr(CSR_BRIGHTNESS, {noise[18:0], bright}, 1'b1);
      write_csr(CSR_PERIOD, period, 1'b0);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_random(int count);
      int          sent;
      int          pick;
      int          col;
      logic [13:0] addr;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            repeat ($urandom_range(1, 8)) begin
               if ($urandom_range(9) == 0) begin
                  addr = 14'($urandom_range(16383));
               end else begin
                  case ($urandom_range(3))
                     0:       col = 0;
                     1:       col = HALF_TURN;
                     2:       col = extra_pair[back_sel()];
                     default: col = extra_pair[back_sel()] + HALF_TURN;
                  endcase
                  addr = 14'(col * COLUMN_BYTES + $urandom_range(COLUMN_BYTES - 1));
               end
               send_request(OP_WRITE, addr, 8'($urandom), noise48());
               if (addr < IMG_BYTES) sent++;
            end
         end else if (pick < 55) begin
            send_request(OP_COMMIT, 14'($urandom), 8'($urandom), noise48());
            sent++;
         end else if (pick < 60) begin
            send_request(OP_INVALIDATE, 14'($urandom), 8'($urandom), noise48());
            sent++;
         end else begin
            send_render(pick_elapsed());
            sent++;
         end
      end
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= OP_WRITE;
      csr_wr_en  <= 1'b0;
      csr_index  <= CSR_STRIP_ENABLE;
      csr_wdata  <= '0;
      extra_pair[0] = $urandom_range(1, HALF_TURN - 1);
      extra_pair[1] = $urandom_range(1, HALF_TURN - 1);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Column pair zero is filled in both banks, so any period has a lit column to hit.
      fill_pair(0);
      send_request(OP_COMMIT, 14'($urandom), 8'($urandom), noise48());
      fill_pair(0);

      // Strip is still off from reset.
      send_render('0);
      send_render(48'(ELAPSED_MAX));
      settle();
      write_csr(CSR_STRIP_ENABLE, 24'hFFFFFF, 1'b0);
      send_render('0);
      send_render(pick_elapsed());
      send_request(OP_COMMIT, 14'($urandom), 8'($urandom), noise48());
      send_render(pick_elapsed());
      send_request(OP_WRITE, 14'(IMG_BYTES), 8'hFF, noise48());
      send_request(OP_WRITE, 14'h3FFF, 8'hFF, noise48());
      send_request(OP_WRITE, 14'(IMG_BYTES - 1), 8'h00, noise48());
      send_request(OP_WRITE, 14'd0, 8'hFF, noise48());
      send_request(OP_INVALIDATE, 14'($urandom), 8'($urandom), noise48());
      send_render('0);
      // With no valid image the writes land in bank zero, which the commit then shows.
      send_request(OP_WRITE, 14'd1, 8'h5A, noise48());
      send_request(OP_COMMIT, 14'($urandom), 8'($urandom), noise48());
      send_render('0);
      send_request(OP_COMMIT, 14'($urandom), 8'($urandom), noise48());
      send_request(OP_COMMIT, 14'($urandom), 8'($urandom), noise48());
      send_render(pick_elapsed());
      settle();
      set_registers(1'b1, 5'd0, 24'd0);
      send_render(48'(ELAPSED_MAX));
      settle();
      set_registers(1'b1, 5'd17, 24'hFFFFFF);
      send_render(48'(ELAPSED_MAX));
      send_render(pick_elapsed());
      settle();
      set_registers(1'b1, 5'd5, 24'd1);
      send_render(pick_elapsed());

      settle();
      set_registers(1'b1, 5'($urandom_range(31)), 24'($urandom_range(128, 24'hFFFFFF)));
      run_random(25);

      settle();
      send_idle_pct = 68;
      recv_idle_pct = 9;
      set_registers(1'b1, 5'($urandom_range(31)), 24'($urandom_range(1, 300)));
      run_random(25);

      settle();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_registers(1'b1, 5'd31, 24'd50000);
      pressure_go <= 1'b1;
      repeat (4) send_render(pick_elapsed());
      run_random(12);
      settle();
      set_registers(1'b0, 5'd0, 24'hFFFFFF);
      run_random(8);
      settle();
      set_registers(1'b1, 5'($urandom_range(31)), 24'($urandom_range(1, 24'hFFFFFF)));
      run_random(10);

      settle();
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
